// ===== sv/csp_pkg.sv =====
// shared types, constants and microcode program of the chaotic sawtooth generator
`default_nettype none
package csp_pkg;

  localparam int REG_W       = 48;
  localparam int SIG_W       = 32;
  localparam int BURN_W      = 16;
  localparam int SEED_W      = 32;
  localparam int OUT_W       = 32;
  localparam int STATE_FRAC  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int UPC_W       = 5;
  localparam int UCODE_LEN   = 19;

  localparam int STATE_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 16;

  localparam logic [SIG_W-1:0]  SAW_HALF_RST = 32'd838861;
  localparam logic [SIG_W-1:0]  SAW_INV_RST  = 32'd167772160;
  localparam logic [BURN_W-1:0] BURN_IN_RST  = 16'd100;

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_ROW_0    = 3'd0,
    REG_MATRIX_ROW_1    = 3'd1,
    REG_MATRIX_ROW_2    = 3'd2,
    REG_GAIN_SIGMA      = 3'd3,
    REG_SAW_HALF_PERIOD = 3'd4,
    REG_SAW_INV_PERIOD  = 3'd5,
    REG_BURN_IN_STEPS   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][REG_W-1:0] matrix_row;
    logic [SIG_W-1:0]      gain_sigma;
    logic [SIG_W-1:0]      saw_half_period;
    logic [SIG_W-1:0]      saw_inv_period;
    logic [BURN_W-1:0]     burn_in_steps;
  } cfg_regs_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MS_SIG_X,
    MS_COEF_X,
    MS_Y_INV,
    MS_L_EPS
  } mul_sel_t;

  // what is done with the product of the previous step
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_Y,
    ACT_L,
    ACT_U,
    ACT_ACC_FIRST,
    ACT_ACC,
    ACT_NX
  } act_t;

  typedef enum logic {
    SEQ_NEXT,
    SEQ_DONE
  } seq_t;

  typedef struct packed {
    mul_sel_t    msel;
    logic [1:0]  m_idx;
    logic [1:0]  m_col;
    act_t        act;
    logic [1:0]  a_idx;
    seq_t        seq;
  } ctrl_word_t;

  function automatic ctrl_word_t mk_cw(input mul_sel_t msel, input logic [1:0] m_idx,
                                       input logic [1:0] m_col, input act_t act,
                                       input logic [1:0] a_idx, input seq_t seq);
    ctrl_word_t w;
    w.msel  = msel;
    w.m_idx = m_idx;
    w.m_col = m_col;
    w.act   = act;
    w.a_idx = a_idx;
    w.seq   = seq;
    return w;
  endfunction

  // one state update: per component gain, round, sawtooth and matrix row
  function automatic ctrl_word_t csp_ucode(input logic [UPC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      5'd0:  w = mk_cw(MS_SIG_X,  2'd0, 2'd0, ACT_NONE,      2'd0, SEQ_NEXT);
      5'd1:  w = mk_cw(MS_COEF_X, 2'd0, 2'd0, ACT_Y,         2'd0, SEQ_NEXT);
      5'd2:  w = mk_cw(MS_Y_INV,  2'd0, 2'd0, ACT_ACC_FIRST, 2'd0, SEQ_NEXT);
      5'd3:  w = mk_cw(MS_COEF_X, 2'd0, 2'd1, ACT_L,         2'd0, SEQ_NEXT);
      5'd4:  w = mk_cw(MS_L_EPS,  2'd0, 2'd0, ACT_ACC,       2'd0, SEQ_NEXT);
      5'd5:  w = mk_cw(MS_COEF_X, 2'd0, 2'd2, ACT_U,         2'd0, SEQ_NEXT);
      5'd6:  w = mk_cw(MS_SIG_X,  2'd1, 2'd0, ACT_NX,        2'd0, SEQ_NEXT);
      5'd7:  w = mk_cw(MS_COEF_X, 2'd1, 2'd0, ACT_Y,         2'd1, SEQ_NEXT);
      5'd8:  w = mk_cw(MS_Y_INV,  2'd1, 2'd0, ACT_ACC_FIRST, 2'd1, SEQ_NEXT);
      5'd9:  w = mk_cw(MS_COEF_X, 2'd1, 2'd1, ACT_L,         2'd1, SEQ_NEXT);
      5'd10: w = mk_cw(MS_L_EPS,  2'd1, 2'd0, ACT_ACC,       2'd1, SEQ_NEXT);
      5'd11: w = mk_cw(MS_COEF_X, 2'd1, 2'd2, ACT_U,         2'd1, SEQ_NEXT);
      5'd12: w = mk_cw(MS_SIG_X,  2'd2, 2'd0, ACT_NX,        2'd1, SEQ_NEXT);
      5'd13: w = mk_cw(MS_COEF_X, 2'd2, 2'd0, ACT_Y,         2'd2, SEQ_NEXT);
      5'd14: w = mk_cw(MS_Y_INV,  2'd2, 2'd0, ACT_ACC_FIRST, 2'd2, SEQ_NEXT);
      5'd15: w = mk_cw(MS_COEF_X, 2'd2, 2'd1, ACT_L,         2'd2, SEQ_NEXT);
      5'd16: w = mk_cw(MS_L_EPS,  2'd2, 2'd0, ACT_ACC,       2'd2, SEQ_NEXT);
      5'd17: w = mk_cw(MS_COEF_X, 2'd2, 2'd2, ACT_U,         2'd2, SEQ_NEXT);
      5'd18: w = mk_cw(MS_SIG_X,  2'd0, 2'd0, ACT_NX,        2'd2, SEQ_DONE);
      default: w = mk_cw(MS_SIG_X, 2'd0, 2'd0, ACT_NONE,     2'd0, SEQ_DONE);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== sv/csp_if.sv =====
// request and result channel interfaces of the chaotic sawtooth generator
`default_nettype none
interface csp_req_if;
  import csp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [SEED_W-1:0] seed_x0;
  logic signed [SEED_W-1:0] seed_x1;
  logic signed [SEED_W-1:0] seed_x2;
  modport source (output valid, command, seed_x0, seed_x1, seed_x2, input ready);
  modport sink (input valid, command, seed_x0, seed_x1, seed_x2, output ready);
endinterface

interface csp_rsp_if;
  import csp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_x0;
  logic signed [OUT_W-1:0] out_x1;
  logic signed [OUT_W-1:0] out_x2;
  modport source (output valid, out_x0, out_x1, out_x2, input ready);
  modport sink (input valid, out_x0, out_x1, out_x2, output ready);
endinterface
`default_nettype wire

// ===== sv/chaotic_sawtooth_prng.sv =====
// top level: request handshake, microcode sequencer, configuration and result register
// a seed request loads the seed state and the burn-in count and gives no result
// a step request runs a 19-word microprogram on one shared multiplier; no new request
// is taken until it is done, and the result is registered only when no burn-in steps remain
// a stalled result holds the last microword until the result register is free
// synchronous active-low reset clears the state to zero and loads register defaults
`default_nettype none
module chaotic_sawtooth_prng #(
  parameter int STATE_WIDTH = csp_pkg::STATE_WIDTH_DEF,
  parameter int COEF_WIDTH  = csp_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  csp_req_if.sink                              in_req,
  csp_rsp_if.source                            out_rsp,
  input  wire logic                            cfg_we,
  input  wire logic [csp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [csp_pkg::REG_W-1:0]       cfg_wdata
);
  import csp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  seq_state_t              state_r;
  logic [UPC_W-1:0]        upc_r;
  logic [BURN_W-1:0]       skip_r;
  logic                    out_valid_r;
  logic [2:0][OUT_W-1:0]   out_x_r;
  cfg_regs_t               cfg_r;

  ctrl_word_t              cw;
  logic                    req_acc;
  logic                    emit;
  logic                    can_finish;
  logic                    adv;
  logic                    done;
  logic [2:0][SEED_W-1:0]  seed;
  logic [2:0][OUT_W-1:0]   commit_x;

  assign cw         = csp_ucode(upc_r);
  assign in_req.ready = (state_r == ST_IDLE);
  assign req_acc    = in_req.valid && in_req.ready;
  assign emit       = (skip_r == '0);
  assign can_finish = !emit || !out_valid_r || out_rsp.ready;
  assign adv        = (state_r == ST_RUN) && (cw.seq == SEQ_NEXT || can_finish);
  assign done       = adv && cw.seq == SEQ_DONE;
  assign seed       = {in_req.seed_x2, in_req.seed_x1, in_req.seed_x0};

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.out_x0 = out_x_r[0];
  assign out_rsp.out_x1 = out_x_r[1];
  assign out_rsp.out_x2 = out_x_r[2];

  csp_datapath #(
    .STATE_WIDTH (STATE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cw       (cw),
    .cfg      (cfg_r),
    .seed_ld  (req_acc && in_req.command == CMD_SEED),
    .seed     (seed),
    .commit_x (commit_x)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (req_acc) begin
            if (in_req.command == CMD_STEP) begin
              state_r <= ST_RUN;
              upc_r   <= '0;
            end else begin
              skip_r <= cfg_r.burn_in_steps;
            end
          end
        end
        ST_RUN: begin
          if (done) begin
            state_r <= ST_IDLE;
            if (emit) begin
              out_valid_r <= 1'b1;
              out_x_r     <= commit_x;
            end else begin
              skip_r <= skip_r - BURN_W'(1);
            end
          end else if (adv) begin
            upc_r <= upc_r + UPC_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_row      <= '0;
      cfg_r.gain_sigma      <= '0;
      cfg_r.saw_half_period <= SAW_HALF_RST;
      cfg_r.saw_inv_period  <= SAW_INV_RST;
      cfg_r.burn_in_steps   <= BURN_IN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MATRIX_ROW_0:    cfg_r.matrix_row[0]   <= cfg_wdata;
        REG_MATRIX_ROW_1:    cfg_r.matrix_row[1]   <= cfg_wdata;
        REG_MATRIX_ROW_2:    cfg_r.matrix_row[2]   <= cfg_wdata;
        REG_GAIN_SIGMA:      cfg_r.gain_sigma      <= cfg_wdata[SIG_W-1:0];
        REG_SAW_HALF_PERIOD: cfg_r.saw_half_period <= cfg_wdata[SIG_W-1:0];
        REG_SAW_INV_PERIOD:  cfg_r.saw_inv_period  <= cfg_wdata[SIG_W-1:0];
        REG_BURN_IN_STEPS:   cfg_r.burn_in_steps   <= cfg_wdata[BURN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/csp_datapath.sv =====
// state registers, shared multiplier and rounding/saturation datapath
`default_nettype none
module csp_datapath #(
  parameter int STATE_WIDTH = csp_pkg::STATE_WIDTH_DEF,
  parameter int COEF_WIDTH  = csp_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire csp_pkg::ctrl_word_t               cw,
  input  wire csp_pkg::cfg_regs_t                cfg,
  input  wire logic                              seed_ld,
  input  wire logic [2:0][csp_pkg::SEED_W-1:0]   seed,
  output logic       [2:0][csp_pkg::OUT_W-1:0]   commit_x
);
  import csp_pkg::*;

  localparam int SW  = STATE_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int CF  = COEF_WIDTH - 2;
  localparam int OBW = SIG_W + 1;
  localparam int PW  = SW + OBW;
  localparam int AW  = PW + 3;
  localparam int RXW = 3 * CW;

  localparam logic signed [AW-1:0] SAT_HI = (AW'(1) <<< (SW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [AW-1:0] HALF_Y = AW'(1) <<< (STATE_FRAC - 1);
  localparam logic signed [AW-1:0] HALF_L = AW'(1) <<< (2 * STATE_FRAC - 1);
  localparam logic signed [AW-1:0] HALF_C = AW'(1) <<< (CF - 1);

  function automatic logic signed [SW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] ext(input logic signed [SW-1:0] v);
    return {{(AW - SW){v[SW-1]}}, v};
  endfunction

  logic signed [SW-1:0] state_r [3];
  logic signed [SW-1:0] nx_r [3];
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] y_r;
  logic signed [SW-1:0] l_r;
  logic signed [SW-1:0] u_r;
  logic signed [AW-1:0] acc_r;

  logic        [RXW-1:0] rowx;
  logic signed [CW-1:0]  coef;
  logic signed [SW-1:0]  opa;
  logic signed [OBW-1:0] opb;
  logic signed [PW-1:0]  prod_nxt;

  logic signed [AW-1:0] pe;
  logic signed [AW-1:0] y_rnd;
  logic signed [AW-1:0] l_rnd;
  logic signed [AW-1:0] saw_diff;
  logic signed [SW-1:0] u_pos;
  logic signed [SW-1:0] u_neg;
  logic signed [SW-1:0] u_val;
  logic signed [AW-1:0] acc_sum;
  logic signed [AW-1:0] acc_rnd;
  logic signed [SW-1:0] mat_val;
  logic signed [SW-1:0] nx_val;
  logic signed [SW-1:0] new_x [3];
  logic signed [AW-1:0] seed_ext [3];

  // operand selection and the shared multiplier
  always_comb begin
    rowx = RXW'(cfg.matrix_row[cw.m_idx]);
    coef = rowx[cw.m_col * CW +: CW];
    case (cw.msel)
      MS_SIG_X: begin
        opa = state_r[cw.m_idx];
        opb = $signed({1'b0, cfg.gain_sigma});
      end
      MS_COEF_X: begin
        opa = state_r[cw.m_col];
        opb = {{(OBW - CW){coef[CW-1]}}, coef};
      end
      MS_Y_INV: begin
        opa = y_r;
        opb = $signed({1'b0, cfg.saw_inv_period});
      end
      MS_L_EPS: begin
        opa = l_r;
        opb = $signed({1'b0, cfg.saw_half_period});
      end
      default: begin
        opa = state_r[cw.m_idx];
        opb = $signed({1'b0, cfg.gain_sigma});
      end
    endcase
    prod_nxt = PW'(opa) * PW'(opb);
  end

  // rounding, sawtooth and row-sum post-processing
  always_comb begin
    pe       = {{(AW - PW){prod_r[PW-1]}}, prod_r};
    y_rnd    = (pe + HALF_Y) >>> STATE_FRAC;
    l_rnd    = (pe + HALF_L) >>> (2 * STATE_FRAC);
    saw_diff = ext(y_r) - (pe <<< 1);
    u_pos    = sat(saw_diff);
    u_neg    = sat(-ext(u_pos));
    u_val    = l_r[0] ? u_neg : u_pos;
    acc_sum  = acc_r + pe;
    acc_rnd  = (acc_sum + HALF_C) >>> CF;
    mat_val  = sat(acc_rnd);
    nx_val   = sat(ext(mat_val) + ext(u_r));
    for (int j = 0; j < 3; j++) begin
      new_x[j]    = (2'(j) == cw.a_idx) ? nx_val : nx_r[j];
      commit_x[j] = OUT_W'(ext(new_x[j]));
      seed_ext[j] = {{(AW - SEED_W){seed[j][SEED_W-1]}}, seed[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        state_r[j] <= '0;
      end
    end else if (seed_ld) begin
      for (int j = 0; j < 3; j++) begin
        state_r[j] <= sat(seed_ext[j]);
      end
    end else if (en && cw.seq == SEQ_DONE) begin
      for (int j = 0; j < 3; j++) begin
        state_r[j] <= new_x[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      case (cw.act)
        ACT_Y:         y_r   <= sat(y_rnd);
        ACT_L:         l_r   <= l_rnd[SW-1:0];
        ACT_U:         u_r   <= u_val;
        ACT_ACC_FIRST: acc_r <= pe;
        ACT_ACC:       acc_r <= acc_sum;
        ACT_NX:        nx_r[cw.a_idx] <= nx_val;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/csp_checker.sv =====
// port-level assertions of the chaotic sawtooth generator and their bind
`default_nettype none
module csp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_command,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_x0,
  input wire logic [31:0] out_x1,
  input wire logic [31:0] out_x2
);
  import csp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x0) && $stable(out_x1) && $stable(out_x2))
    else $error("result changed while stalled");

  a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_SEED |=> !$rose(out_valid))
    else $error("seed request produced a result");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_STEP |=> !in_ready ##17 !in_ready)
    else $error("step request finished early");

endmodule

bind chaotic_sawtooth_prng csp_checker u_csp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_command (in_req.command),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_x0     (out_rsp.out_x0),
  .out_x1     (out_rsp.out_x1),
  .out_x2     (out_rsp.out_x2)
);
`default_nettype wire
